### rtl/mmtb_pkg.sv
// ----------------------------------------------------------------------------
// mmtb_pkg
// shared types, widths and codes for the transposed-operand matrix multiplier
// ----------------------------------------------------------------------------
package mmtb_pkg;

    localparam int MAX_N_DEF  = 64;   // default largest matrix dimension
    localparam int IDX_PORT_W = 6;    // row and column fields on the ports
    localparam int ELEM_W     = 16;   // q8.8 element
    localparam int PROD_W     = 2 * ELEM_W;
    localparam int ACC_W      = 38;   // q22.16 dot product
    localparam int CFG_W      = 7;    // matrix_size register
    localparam logic [CFG_W-1:0] SIZE_RESET = 7'd64;

    localparam int IN_DATA_W  = 48;   // row, col, a_value, b_value, zero pad
    localparam int OUT_DATA_W = 56;   // out_row, out_col, product_value, zero pad

    // request kinds carried in tuser
    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_READ = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic mem_we;    // write one element of each matrix
        logic start;     // latch read indices, clear accumulator
        logic issue;     // read one pair of elements at column k
        logic out_load;  // move the finished sum into the output register
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic busy;      // products still in flight
        logic out_free;  // output register can take a result this cycle
    } t_stat;

endpackage

### rtl/mmtb_ctrl.sv
// ----------------------------------------------------------------------------
// mmtb_ctrl
// request sequencer: decodes requests and steps the column counter of a read
// ----------------------------------------------------------------------------
module mmtb_ctrl #(
    parameter int MAX_N = mmtb_pkg::MAX_N_DEF,
    parameter int IDX_W = $clog2(MAX_N)
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic                                i_req_type,
    input  logic [mmtb_pkg::IDX_PORT_W-1:0]     i_row,
    input  logic [mmtb_pkg::IDX_PORT_W-1:0]     i_col,
    input  logic [mmtb_pkg::CFG_W-1:0]          i_matrix_size,
    input  mmtb_pkg::t_stat                     i_stat,
    output mmtb_pkg::t_cmd                      o_cmd,
    output logic [IDX_W-1:0]                    o_k
);
    import mmtb_pkg::*;

    localparam int CNT_W = $clog2(MAX_N + 1);
    localparam int CMP_W = IDX_PORT_W + 1;

    t_state r_state, n_state;
    logic [CNT_W-1:0] r_k, n_k;
    logic [CNT_W-1:0] r_n, n_n;

    logic             accept;
    logic             in_range;
    logic [CNT_W-1:0] size_eff;
    logic [CNT_W-1:0] size_req;
    logic             last_issue;

    // requests are taken only while idle
    assign accept   = i_in_valid && (r_state == ST_IDLE);
    assign in_range = ({1'b0, i_row} < CMP_W'(MAX_N)) && ({1'b0, i_col} < CMP_W'(MAX_N));
    // sizes above the store dimension fall back to the full matrix
    assign size_eff = (i_matrix_size > CFG_W'(MAX_N)) ? CNT_W'(MAX_N)
                                                      : CNT_W'(i_matrix_size);
    // out-of-range reads sum no terms
    assign size_req   = in_range ? size_eff : '0;
    assign last_issue = (r_k + CNT_W'(1)) == r_n;
    assign o_k        = r_k[IDX_W-1:0];

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept && i_req_type == REQ_READ) begin
                    n_state = (size_req == '0) ? ST_DRAIN : ST_RUN;
                end
            end
            ST_RUN: begin
                if (last_issue) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (o_cmd.out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.mem_we = accept && i_req_type == REQ_LOAD && in_range;
                o_cmd.start  = accept && i_req_type == REQ_READ;
            end
            ST_RUN: begin
                o_cmd.issue = 1'b1;
            end
            ST_DRAIN: begin
                o_cmd.out_load = !i_stat.busy && i_stat.out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    // column counter and bound
    always_comb begin
        n_k = r_k;
        n_n = r_n;
        if (o_cmd.start) begin
            n_k = '0;
            n_n = size_req;
        end else if (o_cmd.issue) begin
            n_k = r_k + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_k     <= '0;
            r_n     <= '0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            r_n     <= n_n;
        end
    end

endmodule

### rtl/mmtb_dp.sv
// ----------------------------------------------------------------------------
// mmtb_dp
// element stores, multiply-accumulate pipeline and output register
// ----------------------------------------------------------------------------
module mmtb_dp #(
    parameter int MAX_N = mmtb_pkg::MAX_N_DEF,
    parameter int IDX_W = $clog2(MAX_N)
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  mmtb_pkg::t_cmd                      i_cmd,
    input  logic [IDX_W-1:0]                    i_k,
    input  logic [mmtb_pkg::IDX_PORT_W-1:0]     i_row,
    input  logic [mmtb_pkg::IDX_PORT_W-1:0]     i_col,
    input  logic [mmtb_pkg::ELEM_W-1:0]         i_a_value,
    input  logic [mmtb_pkg::ELEM_W-1:0]         i_b_value,
    output mmtb_pkg::t_stat                     o_stat,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [mmtb_pkg::OUT_DATA_W-1:0]     o_out_data
);
    import mmtb_pkg::*;

    localparam int ADDR_W = 2 * IDX_W;
    localparam int DEPTH  = 1 << ADDR_W;
    localparam int PAD_W  = OUT_DATA_W - 2 * IDX_PORT_W - ACC_W;

    logic [ELEM_W-1:0] mem_a [DEPTH];
    logic [ELEM_W-1:0] mem_b [DEPTH];

    logic [IDX_PORT_W-1:0]    r_row, r_col;
    logic signed [ELEM_W-1:0] r_a_q, r_b_q;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic                     r_rd_v, r_prod_v;
    logic                     r_out_valid;
    logic [IDX_PORT_W-1:0]    r_out_row, r_out_col;
    logic [ACC_W-1:0]         r_out_sum;

    logic [ADDR_W-1:0] wr_addr, rd_addr_a, rd_addr_b;

    assign wr_addr   = {i_row[IDX_W-1:0], i_col[IDX_W-1:0]};
    // a runs along its row, b along row col (the transposed operand)
    assign rd_addr_a = {r_row[IDX_W-1:0], i_k};
    assign rd_addr_b = {r_col[IDX_W-1:0], i_k};

    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_we) begin
            mem_a[wr_addr] <= i_a_value;
            mem_b[wr_addr] <= i_b_value;
        end
        if (i_cmd.issue) begin
            r_a_q <= $signed(mem_a[rd_addr_a]);
            r_b_q <= $signed(mem_b[rd_addr_b]);
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_row <= i_row;
            r_col <= i_col;
        end
        r_prod <= r_a_q * r_b_q;
        if (i_cmd.start) begin
            r_acc <= '0;
        end else if (r_prod_v) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
        if (i_cmd.out_load) begin
            r_out_row <= r_row;
            r_out_col <= r_col;
            r_out_sum <= r_acc;
        end
    end

    // control bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_v      <= 1'b0;
            r_prod_v    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_rd_v   <= i_cmd.issue;
            r_prod_v <= r_rd_v;
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stat.busy     = r_rd_v || r_prod_v;
    assign o_stat.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_out_data      = {PAD_W'(0), r_out_sum, r_out_col, r_out_row};

endmodule

### rtl/matrix_multiply_transposed_b.sv
// ----------------------------------------------------------------------------
// matrix_multiply_transposed_b
// square matrix store with dot-product readout of a times b transposed
// ----------------------------------------------------------------------------
// usage
//   s_axis carries requests: tuser selects load (0) or read (1). a load writes
//   a_value into a(row, col) and b_value into b(row, col) and returns nothing.
//   a read returns one m_axis result: the sum over k < matrix_size of
//   a(row, k) * b(col, k) in q22.16, together with its row and col.
//   the cfg channel writes matrix_size (0..127, above MAX_N counts as MAX_N);
//   write it only while no request is in progress.
// sequencing
//   a load is written in the cycle it is accepted; the channel stays ready.
//   a read holds the request channel while it steps one column per cycle
//   through the single read port of each store, then through the read,
//   multiply and accumulate stages, until its sum is moved into the output
//   register; no new request is taken before that.
//   a read at size zero skips the stores and goes straight to that handover.
// reset and stall
//   reset clears the sequencer and output valid and sets matrix_size to 64;
//   store contents are undefined until loaded. a stalled result waits in the
//   output register while loads and the next read go ahead; that read then
//   waits for the slot before its sum is handed over.
// ----------------------------------------------------------------------------
module matrix_multiply_transposed_b #(
    parameter int MAX_N = mmtb_pkg::MAX_N_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // request stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [mmtb_pkg::IN_DATA_W-1:0]    s_axis_tdata,  // row, col, a_value, b_value
    input  logic                              s_axis_tuser,  // req_type
    // result stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [mmtb_pkg::OUT_DATA_W-1:0]   m_axis_tdata,  // out_row, out_col, product_value
    // matrix_size register write
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [mmtb_pkg::CFG_W-1:0]        i_cfg_data
);
    import mmtb_pkg::*;

    localparam int IDX_W = $clog2(MAX_N);

    logic [CFG_W-1:0]      r_matrix_size;
    t_cmd                  cmd;
    t_stat                 stat;
    logic [IDX_W-1:0]      k_idx;
    logic [IDX_PORT_W-1:0] in_row, in_col;
    logic [ELEM_W-1:0]     in_a, in_b;

    // unpack request fields, lowest bits first
    assign in_row = s_axis_tdata[IDX_PORT_W-1:0];
    assign in_col = s_axis_tdata[2*IDX_PORT_W-1:IDX_PORT_W];
    assign in_a   = s_axis_tdata[2*IDX_PORT_W+ELEM_W-1:2*IDX_PORT_W];
    assign in_b   = s_axis_tdata[2*IDX_PORT_W+2*ELEM_W-1:2*IDX_PORT_W+ELEM_W];

    // register always writable
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_matrix_size <= SIZE_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_matrix_size <= i_cfg_data;
        end
    end

    mmtb_ctrl #(
        .MAX_N (MAX_N),
        .IDX_W (IDX_W)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (s_axis_tvalid),
        .o_in_ready    (s_axis_tready),
        .i_req_type    (s_axis_tuser),
        .i_row         (in_row),
        .i_col         (in_col),
        .i_matrix_size (r_matrix_size),
        .i_stat        (stat),
        .o_cmd         (cmd),
        .o_k           (k_idx)
    );

    mmtb_dp #(
        .MAX_N (MAX_N),
        .IDX_W (IDX_W)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_k         (k_idx),
        .i_row       (in_row),
        .i_col       (in_col),
        .i_a_value   (in_a),
        .i_b_value   (in_b),
        .o_stat      (stat),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (m_axis_tdata)
    );

    // a finished sum never overwrites a result still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> (!m_axis_tvalid || m_axis_tready))
        else $error("result overwritten while stalled");

    // the sum is handed over only after the pipeline has drained
    a_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> !stat.busy)
        else $error("result taken with products in flight");

    // no request is taken while a read is stepping through the stores
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.issue |-> (!s_axis_tready && !cmd.mem_we))
        else $error("request accepted during a read");

    // a read start is followed by column reads or straight by the drain
    a_start_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.start |=> (cmd.issue || !s_axis_tready))
        else $error("read start lost");

endmodule

### tb/matrix_multiply_transposed_b_test.sv
// ----------------------------------------------------------------------------
// matrix_multiply_transposed_b_test
// self-checking bench for the a times b-transposed dot-product store
// ----------------------------------------------------------------------------
// a local copy of both matrices and of matrix_size predicts every read request
// as it is accepted. results are checked in order against that prediction.
// the run covers the reset size, the size corners (zero, one, full, above full),
// a long output stall that backs up the request channel, and random phases of
// loads and reads under many sizes. requests are sent in bursts with gaps while
// the result side stalls on patterns of its own.
// ----------------------------------------------------------------------------
module matrix_multiply_transposed_b_test;

    import mmtb_pkg::*;

    localparam int MAX_N         = MAX_N_DEF;
    localparam int CLK_HALF      = 6;
    localparam int SETTLE_CYCLES = 80;
    localparam int HOLD_CYCLES   = 400;       // long result-side hold-off
    localparam int RANDOM_TARGET = 1700;      // requests before the random part stops
    localparam int TIMEOUT       = 12_000_000;

    // result-side stall patterns
    typedef enum int {
        RX_STEADY,
        RX_COIN,
        RX_SPARSE
    } t_rx_mode;

    // one predicted element of a times b transposed
    typedef struct {
        logic [5:0]         row;
        logic [5:0]         col;
        logic signed [37:0] value;
    } t_product;

    // ------------------------------------------------------------------------
    // dut connections, all inputs known from time zero
    // ------------------------------------------------------------------------
    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;    // row, col, a_value, b_value
    logic                  s_axis_tuser  = 1'b0;  // req_type
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;          // out_row, out_col, product_value
    logic                  i_cfg_valid   = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_W-1:0]      i_cfg_data    = '0;

    matrix_multiply_transposed_b #(
        .MAX_N (MAX_N)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    // ------------------------------------------------------------------------
    // predictor state: both matrices, which entries hold a loaded value,
    // and the size in force
    // ------------------------------------------------------------------------
    logic signed [15:0] mat_a [MAX_N][MAX_N];
    logic signed [15:0] mat_b [MAX_N][MAX_N];
    bit                 loaded [MAX_N][MAX_N];
    logic [CFG_W-1:0]   active_size = SIZE_RESET;

    t_product products_due [$];

    int mismatches      = 0;
    int products_seen   = 0;
    int requests_sent   = 0;
    int loads_sent      = 0;
    int reads_sent      = 0;
    int size_writes     = 0;
    int burst_left      = 0;
    int hold_requests   = 0;   // bumped by the stimulus, served by the receiver

    // ------------------------------------------------------------------------
    // clock and watchdog
    // ------------------------------------------------------------------------
    initial begin
        forever #(CLK_HALF) i_clk = ~i_clk;
    end

    initial begin
        #(TIMEOUT);
        $display("Verification failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------------

    // columns summed: sizes above the store depth count as the full depth
    function automatic int terms_in_use();
        int n;
        n = active_size;
        if (n > MAX_N)
            n = MAX_N;
        return n;
    endfunction

    // element (r, c) of a times b transposed, q22.16, exact in 38 bits
    function automatic logic signed [37:0] a_bt_element(input logic [5:0] r,
                                                         input logic [5:0] c);
        longint sum;
        int     n;
        sum = 0;
        n   = terms_in_use();
        for (int k = 0; k < n; k++)
            sum += longint'(mat_a[r][k]) * longint'(mat_b[c][k]);
        return sum[37:0];
    endfunction

    // a row can take part in a read once its first n entries are loaded
    function automatic bit row_complete(input int r);
        int n;
        n = terms_in_use();
        for (int k = 0; k < n; k++)
            if (!loaded[r][k])
                return 1'b0;
        return 1'b1;
    endfunction

    // random element, the extremes and minus one weighted up
    function automatic logic [15:0] random_element();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'hffff;
            default: return 16'($urandom);
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------------
    task automatic note_mismatch(input string what, input longint want, input longint got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch on %s: expected %0d, got %0d", what, want, got);
    endtask

    initial begin
        t_product           due;
        logic [5:0]         got_row;
        logic [5:0]         got_col;
        logic signed [37:0] got_value;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
                got_row   = m_axis_tdata[5:0];
                got_col   = m_axis_tdata[11:6];
                got_value = m_axis_tdata[49:12];
                products_seen++;
                if (products_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result for row %0d col %0d with no read outstanding",
                                 got_row, got_col);
                end else begin
                    due = products_due.pop_front();
                    if (got_row != due.row)
                        note_mismatch("out_row", due.row, got_row);
                    if (got_col != due.col)
                        note_mismatch("out_col", due.col, got_col);
                    if (got_value != due.value)
                        note_mismatch("product_value", due.value, got_value);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // result side: randomly chosen stall patterns,
    // plus a long hold-off whenever the stimulus asks for one
    // ------------------------------------------------------------------------
    initial begin
        t_rx_mode mode;
        int       mode_left;
        int       hold_left;
        int       holds_served;
        mode_left    = 0;
        hold_left    = 0;
        holds_served = 0;
        mode         = RX_STEADY;
        forever begin
            @(posedge i_clk);
            if (holds_served != hold_requests) begin
                holds_served = hold_requests;
                hold_left    = HOLD_CYCLES;
            end
            if (mode_left == 0) begin
                mode      = t_rx_mode'($urandom_range(0, 2));
                mode_left = $urandom_range(32, 256);
            end
            mode_left--;
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                case (mode)
                    RX_STEADY: m_axis_tready <= 1'b1;
                    RX_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
                    default:   m_axis_tready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // request side
    // ------------------------------------------------------------------------

    // update the copy of the stores, or queue the product a read will return
    task automatic record_request(input logic kind, input logic [5:0] row,
                                  input logic [5:0] col, input logic [15:0] a_val,
                                  input logic [15:0] b_val);
        t_product p;
        requests_sent++;
        if (kind == REQ_LOAD) begin
            mat_a[row][col]  = a_val;
            mat_b[row][col]  = b_val;
            loaded[row][col] = 1'b1;
            loads_sent++;
        end else begin
            p.row   = row;
            p.col   = col;
            p.value = a_bt_element(row, col);
            products_due.push_back(p);
            reads_sent++;
        end
    endtask

    // offer one request; bursts of random length with random gaps, valid is
    // left high on return so the next request can follow without a bubble
    task automatic send_request(input logic kind, input logic [5:0] row,
                                input logic [5:0] col, input logic [15:0] a_val,
                                input logic [15:0] b_val);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {4'b0, b_val, a_val, col, row};
        do
            @(posedge i_clk);
        while (!s_axis_tready);
        record_request(kind, row, col, a_val, b_val);
    endtask

    task automatic send_load(input int row, input int col, input logic [15:0] a_val,
                             input logic [15:0] b_val);
        send_request(REQ_LOAD, 6'(row), 6'(col), a_val, b_val);
    endtask

    // element fields of a read carry noise, the block ignores them
    task automatic send_read(input int row, input int col);
        send_request(REQ_READ, 6'(row), 6'(col), 16'($urandom), 16'($urandom));
    endtask

    // stop offering, let every read come back and the last one drain out
    task automatic settle_block();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (products_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // matrix_size is only written with the block idle
    task automatic write_size(input int size);
        settle_block();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= CFG_W'(size);
        do
            @(posedge i_clk);
        while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        active_size = CFG_W'(size);
        size_writes++;
    endtask

    // load whatever is still missing of the first n entries of a row
    task automatic complete_row(input int r);
        int n;
        n = terms_in_use();
        for (int k = 0; k < n; k++)
            if (!loaded[r][k])
                send_load(r, k, random_element(), random_element());
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // size 64 straight out of reset, with the largest sums of both signs;
    // then a size above the store depth must give the same sums
    task automatic test_reset_size();
        for (int k = 0; k < MAX_N; k++)
            send_load(0, k, 16'h8000, 16'h8000);
        for (int k = 0; k < MAX_N; k++)
            send_load(1, k, 16'h7fff, 16'h7fff);
        send_read(0, 0);
        send_read(0, 1);
        send_read(1, 0);
        send_read(1, 1);
        write_size(127);
        send_read(0, 0);
        send_read(1, 0);
        send_read(0, 1);
        send_read(1, 1);
    endtask

    // size zero sums nothing, so even untouched rows read back as zero;
    // loads beyond the size in use still land and count once it grows
    task automatic test_size_corners();
        write_size(0);
        send_read(63, 63);
        send_read(17, 42);
        send_read(0, 1);
        write_size(1);
        send_load(63, 0, 16'h8000, 16'h7fff);
        send_load(63, 1, 16'h0001, 16'hffff);
        send_load(63, 63, 16'hffff, 16'h0001);
        send_read(63, 63);
        send_read(63, 0);
        send_read(0, 63);
        send_read(1, 63);
        write_size(2);
        send_read(63, 63);
        send_read(63, 1);
        send_read(0, 63);
        send_load(63, 1, 16'h7fff, 16'h8000);
        send_read(63, 63);
        send_read(1, 63);
    endtask

    // the result side holds off for a long stretch while reads keep coming,
    // so the output register fills and the request channel backs up
    task automatic test_output_stall();
        int rows [3];
        write_size(4);
        rows = '{0, 1, 5};
        complete_row(5);
        hold_requests++;
        for (int i = 0; i < 36; i++) begin
            if (i % 6 == 5)
                send_load($urandom_range(6, 63), $urandom_range(0, 63),
                          random_element(), random_element());
            else
                send_read(rows[$urandom_range(0, 2)], rows[$urandom_range(0, 2)]);
        end
    endtask

    // phases under random sizes: complete a few rows, then mostly reads among
    // complete rows mixed with loads anywhere
    task automatic test_random_sizes();
        int size;
        int wanted;
        int r;
        int c;
        int ready_rows [$];
        bit is_ready [MAX_N];
        while (requests_sent < RANDOM_TARGET) begin
            case ($urandom_range(0, 11))
                0:       size = 0;
                1:       size = $urandom_range(MAX_N + 1, 127);
                2:       size = MAX_N;
                3, 4:    size = $urandom_range(13, MAX_N - 1);
                default: size = $urandom_range(1, 12);
            endcase
            write_size(size);

            ready_rows.delete();
            for (int i = 0; i < MAX_N; i++) begin
                is_ready[i] = row_complete(i);
                if (is_ready[i])
                    ready_rows.push_back(i);
            end
            wanted = (terms_in_use() > 32) ? 2 : $urandom_range(2, 5);
            while (ready_rows.size() < wanted) begin
                r = $urandom_range(0, MAX_N - 1);
                if (!is_ready[r]) begin
                    complete_row(r);
                    is_ready[r] = 1'b1;
                    ready_rows.push_back(r);
                end
            end

            repeat ($urandom_range(40, 110)) begin
                if ($urandom_range(0, 9) < 6) begin
                    send_read(ready_rows[$urandom_range(0, ready_rows.size() - 1)],
                              ready_rows[$urandom_range(0, ready_rows.size() - 1)]);
                end else begin
                    r = $urandom_range(0, MAX_N - 1);
                    c = $urandom_range(0, MAX_N - 1);
                    send_load(r, c, random_element(), random_element());
                    if (!is_ready[r] && row_complete(r)) begin
                        is_ready[r] = 1'b1;
                        ready_rows.push_back(r);
                    end
                end
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_size();
        test_size_corners();
        test_output_stall();
        test_random_sizes();
        settle_block();

        $display("run covered %0d loads and %0d reads across %0d matrix_size writes",
                 loads_sent, reads_sent, size_writes);
        $display("sizes zero, one, full and above full, one %0d-cycle result hold-off, %0d products compared",
                 HOLD_CYCLES, products_seen);
        if (mismatches == 0 && products_due.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

### sim.f
rtl/mmtb_pkg.sv
rtl/mmtb_ctrl.sv
rtl/mmtb_dp.sv
rtl/matrix_multiply_transposed_b.sv
tb/matrix_multiply_transposed_b_test.sv
